// File: hdl/crd_pkg.sv
package crd_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 16;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_GET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DEL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_RES = 8'd3;

    localparam logic [DATA_W-1:0] RST_CODE_GET = 8'd1;
    localparam logic [DATA_W-1:0] RST_CODE_SET = 8'd2;
    localparam logic [DATA_W-1:0] RST_CODE_DEL = 8'd3;
    localparam logic [DATA_W-1:0] RST_CODE_RES = 8'd4;

    localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RES = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_HEADER = 3'd1,
        KIND_KEY    = 3'd2,
        KIND_VALUE  = 3'd3,
        KIND_DONE   = 3'd4,
        KIND_BAD    = 3'd5
    } kind_t;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_LEN_HI   = 6'b000010,
        PH_LEN_LO   = 6'b000100,
        PH_PAYLOAD  = 6'b001000,
        PH_DONE     = 6'b010000,
        PH_REJECTED = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  payload;
        logic [CMD_W-1:0]   command;
    } result_t;

endpackage

// File: hdl/cache_request_deframer_core.sv
// Request deframer for a byte-wide cache connection stream.
// Input channel (s_): one connection byte per transfer; s_tuser flags the
// first byte of a new connection, which restarts the parser (codes are kept).
// Result channel (m_): exactly one result per input transfer; m_tuser is the
// result kind (none, header, key byte, value byte, complete, bad request),
// m_tdata carries the key/value byte and the matched command.
// Config channel (cfg_): writes header codes get/set/del/res at indexes 0..3;
// writes to other indexes are taken and dropped. cfg_ready is always high.
// Throughput: one byte per cycle while s_tready is high; parser state updates per byte.
// A two-entry output stage (result register plus skid register) lets an input
// transfer land while a result waits; s_tready drops only when both are full.
// Reset (aresetn low, synchronous): parser waits for a header, codes return
// to 1/2/3/4, output stage empties. The first byte after reset is a header.
module cache_request_deframer_core
    import crd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] conn_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] payload, [9:8] command, [15:10] zero
    output logic [KIND_W-1:0]     m_tuser,   // [2:0] kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    logic [DATA_W-1:0] code_get_reg, code_set_reg, code_del_reg, code_res_reg;

    phase_t            phase_reg, phase_next, cur_phase;
    logic              in_value_reg, in_value_next, cur_in_value;
    logic [CMD_W-1:0]  cmd_index_reg, cmd_index_next, cur_cmd_index;
    logic [DATA_W-1:0] length_high_reg, length_high_next, cur_length_high;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next, cur_bytes_left;
    logic [LEN_W-1:0]  len;

    result_t res;
    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    s_accept, pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign pop       = main_valid_reg && m_tready;

    assign m_tvalid = main_valid_reg;
    assign m_tuser  = main_reg.kind;
    assign m_tdata  = {6'b0, main_reg.command, main_reg.payload};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_get_reg <= RST_CODE_GET;
            code_set_reg <= RST_CODE_SET;
            code_del_reg <= RST_CODE_DEL;
            code_res_reg <= RST_CODE_RES;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CODE_GET: code_get_reg <= cfg_data;
                REG_CODE_SET: code_set_reg <= cfg_data;
                REG_CODE_DEL: code_del_reg <= cfg_data;
                REG_CODE_RES: code_res_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_phase       = s_tuser ? PH_HEADER : phase_reg;
        cur_in_value    = s_tuser ? 1'b0 : in_value_reg;
        cur_cmd_index   = s_tuser ? CMD_GET : cmd_index_reg;
        cur_length_high = s_tuser ? '0 : length_high_reg;
        cur_bytes_left  = s_tuser ? '0 : bytes_left_reg;

        phase_next       = cur_phase;
        in_value_next    = cur_in_value;
        cmd_index_next   = cur_cmd_index;
        length_high_next = cur_length_high;
        bytes_left_next  = cur_bytes_left;

        len = {cur_length_high, s_tdata};
        res = '{kind: KIND_NONE, payload: '0, command: CMD_GET};

        unique case (cur_phase)
            PH_HEADER: begin
                // first matching code wins, in get/set/del/res order
                if (s_tdata == code_get_reg) begin
                    cmd_index_next = CMD_GET;
                end else if (s_tdata == code_set_reg) begin
                    cmd_index_next = CMD_SET;
                end else if (s_tdata == code_del_reg) begin
                    cmd_index_next = CMD_DEL;
                end else begin
                    cmd_index_next = CMD_RES;
                end
                if (s_tdata == code_get_reg || s_tdata == code_set_reg ||
                    s_tdata == code_del_reg || s_tdata == code_res_reg) begin
                    in_value_next = 1'b0;
                    phase_next    = PH_LEN_HI;
                    res.kind      = KIND_HEADER;
                    res.command   = cmd_index_next;
                end else begin
                    cmd_index_next = cur_cmd_index;
                    phase_next     = PH_REJECTED;
                    res.kind       = KIND_BAD;
                end
            end
            PH_LEN_HI: begin
                length_high_next = s_tdata;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (len != '0) begin
                    bytes_left_next = len;
                    phase_next      = PH_PAYLOAD;
                end else if (!cur_in_value && cur_cmd_index == CMD_SET) begin
                    in_value_next = 1'b1;
                    phase_next    = PH_LEN_HI;
                end else begin
                    phase_next  = PH_DONE;
                    res.kind    = KIND_DONE;
                    res.command = cur_cmd_index;
                end
            end
            PH_PAYLOAD: begin
                res.kind    = cur_in_value ? KIND_VALUE : KIND_KEY;
                res.payload = s_tdata;
                res.command = cur_cmd_index;
                if (cur_bytes_left != '0) begin
                    bytes_left_next = cur_bytes_left - LEN_W'(1);
                end
                if (bytes_left_next == '0) begin
                    phase_next = PH_LEN_HI;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            in_value_reg    <= 1'b0;
            cmd_index_reg   <= CMD_GET;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
        end else if (s_accept) begin
            phase_reg       <= phase_next;
            in_value_reg    <= in_value_next;
            cmd_index_reg   <= cmd_index_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    // output stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!main_valid_reg || pop) begin
                main_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end else if (pop && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while result register empty");

    a_payload_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload phase with zero bytes left");

    a_payload_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && main_reg.kind != KIND_KEY && main_reg.kind != KIND_VALUE
        |-> main_reg.payload == '0)
        else $error("payload set on a non-data result");

    a_cmd_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && (main_reg.kind == KIND_NONE || main_reg.kind == KIND_BAD)
        |-> main_reg.command == CMD_GET)
        else $error("command set on an empty or bad result");

    a_value_only_set: assert property (@(posedge aclk) disable iff (!aresetn)
        in_value_reg && phase_reg != PH_HEADER |-> cmd_index_reg == CMD_SET)
        else $error("value section entered for a non-store command");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import crd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 240;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    cache_request_deframer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser shadow
    logic [DATA_W-1:0] hdr_code [0:3];
    phase_t            pr_phase;
    logic              pr_in_value;
    logic [CMD_W-1:0]  pr_cmd;
    logic [7:0]        pr_len_hi;
    logic [LEN_W-1:0]  pr_left;

    result_t expected_results[$];
    result_t want;
    int      err_count;
    int      items_sent;
    int      cycles;
    logic    no_idle;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
    end

    function automatic void clear_parser();
        pr_phase    = PH_HEADER;
        pr_in_value = 1'b0;
        pr_cmd      = CMD_GET;
        pr_len_hi   = '0;
        pr_left     = '0;
    endfunction

    function automatic result_t deframe_byte(input logic [7:0] b, input logic start);
        result_t          r;
        logic [LEN_W-1:0] len;
        r.kind    = KIND_NONE;
        r.payload = '0;
        r.command = '0;
        if (start)
            clear_parser();
        case (pr_phase)
            PH_HEADER: begin
                if (b == hdr_code[CMD_GET]) begin
                    pr_cmd = CMD_GET;
                    r.kind = KIND_HEADER;
                end else if (b == hdr_code[CMD_SET]) begin
                    pr_cmd = CMD_SET;
                    r.kind = KIND_HEADER;
                end else if (b == hdr_code[CMD_DEL]) begin
                    pr_cmd = CMD_DEL;
                    r.kind = KIND_HEADER;
                end else if (b == hdr_code[CMD_RES]) begin
                    pr_cmd = CMD_RES;
                    r.kind = KIND_HEADER;
                end else begin
                    r.kind   = KIND_BAD;
                    pr_phase = PH_REJECTED;
                end
                if (r.kind == KIND_HEADER) begin
                    pr_in_value = 1'b0;
                    pr_phase    = PH_LEN_HI;
                    r.command   = pr_cmd;
                end
            end
            PH_LEN_HI: begin
                pr_len_hi = b;
                pr_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len = {pr_len_hi, b};
                if (len != '0) begin
                    pr_left  = len;
                    pr_phase = PH_PAYLOAD;
                end else if (!pr_in_value && pr_cmd == CMD_SET) begin
                    pr_in_value = 1'b1;
                    pr_phase    = PH_LEN_HI;
                end else begin
                    pr_phase  = PH_DONE;
                    r.kind    = KIND_DONE;
                    r.command = pr_cmd;
                end
            end
            PH_PAYLOAD: begin
                r.kind    = pr_in_value ? KIND_VALUE : KIND_KEY;
                r.payload = b;
                r.command = pr_cmd;
                if (pr_left != '0)
                    pr_left = pr_left - LEN_W'(1);
                if (pr_left == '0)
                    pr_phase = PH_LEN_HI;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, what);
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer kind=%0d tdata=%h",
                    m_tuser, m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.payload ||
                        m_tdata[9:8] !== want.command)
                    note_mismatch($sformatf(
                        "kind exp %0d got %0d, payload exp %h got %h, cmd exp %0d got %0d",
                        want.kind, m_tuser, want.payload, m_tdata[7:0],
                        want.command, m_tdata[9:8]));
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_results.push_back(deframe_byte(b, start));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_CODE_GET: hdr_code[CMD_GET] = val;
            REG_CODE_SET: hdr_code[CMD_SET] = val;
            REG_CODE_DEL: hdr_code[CMD_DEL] = val;
            REG_CODE_RES: hdr_code[CMD_RES] = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_codes(input logic [7:0] g, input logic [7:0] s,
                             input logic [7:0] d, input logic [7:0] r);
        wait_idle();
        write_reg(REG_CODE_GET, g);
        write_reg(REG_CODE_SET, s);
        write_reg(REG_CODE_DEL, d);
        write_reg(REG_CODE_RES, r);
        // unmapped index must be dropped
        write_reg(CFG_IDX_W'($urandom_range(REG_CODE_RES + 1, 255)), 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_seq(input logic [7:0] bytes[$], input logic first_start);
        foreach (bytes[i])
            send_byte(bytes[i], (i == 0) ? first_start : 1'b0);
    endtask

    task automatic test_first_byte_is_header();
        // no connection start after reset; get with one-byte key
        send_seq('{8'h01, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h55}, 1'b0);
    endtask

    task automatic test_store_request();
        // empty key, one value byte, zero length ends value
        send_seq('{8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1);
    endtask

    task automatic test_delete_response_and_reject();
        send_seq('{8'h03, 8'h00, 8'h00}, 1'b1);
        send_seq('{8'h04, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00}, 1'b1);
        send_seq('{8'hFF, 8'h01}, 1'b1);
    endtask

    task automatic test_restart_mid_request();
        send_seq('{8'h01, 8'h00, 8'h03, 8'h11}, 1'b1);
        send_seq('{8'h02, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
    endtask

    task automatic test_header_codes();
        // overlapping codes: get beats the others, set beats del
        set_codes(8'h00, 8'hFF, 8'hFF, 8'h00);
        send_seq('{8'h00, 8'h00, 8'h00}, 1'b1);
        send_seq('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
        set_codes(8'hA5, 8'hA5, 8'hA5, 8'hA5);
        send_seq('{8'hA5, 8'h00, 8'h00}, 1'b1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(250, 300);
    endfunction

    task automatic add_chunks(ref logic [7:0] q[$], input int n);
        int len;
        repeat (n) begin
            len = pick_len();
            q.push_back(8'(len >> 8));
            q.push_back(8'(len));
            repeat (len) q.push_back(8'($urandom));
        end
        q.push_back(8'h00);
        q.push_back(8'h00);
    endtask

    task automatic send_random_request();
        logic [7:0] q[$];
        logic       flags[$];
        int         r;
        int         cmd;
        int         n;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            cmd = $urandom_range(0, 3);
            q.push_back(hdr_code[cmd]);
            add_chunks(q, $urandom_range(0, 3));
            if (cmd == CMD_SET)
                add_chunks(q, $urandom_range(0, 3));
            if (r >= 70) begin
                n = $urandom_range(1, q.size() - 1);
                while (q.size() > n) void'(q.pop_back());
            end else if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            end
        end else if (r < 93) begin
            // accepted header, then garbage
            q.push_back(hdr_code[$urandom_range(0, 3)]);
            repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                q.push_back(8'($urandom));
                flags.push_back($urandom_range(0, 3) == 0);
            end
        end
        foreach (q[i]) begin
            if (flags.size() != 0)
                send_byte(q[i], flags[i]);
            else
                send_byte(q[i], (i == 0) ? ($urandom_range(0, 19) != 0) : 1'b0);
        end
        if ($urandom_range(0, 40) == 0)
            wait_idle();
    endtask

    task automatic run_phase(input int target);
        while (items_sent < target)
            send_random_request();
    endtask

    task automatic test_random_traffic();
        logic [7:0] dup;
        int         target;
        target = items_sent;
        set_codes(RST_CODE_GET, RST_CODE_SET, RST_CODE_DEL, RST_CODE_RES);
        target += PHASE_ITEMS;
        run_phase(target);
        set_codes(8'h00, 8'hFF, 8'h7F, 8'h80);
        target += PHASE_ITEMS / 2;
        run_phase(target);
        // sender holds off until the result side has caught up
        wait_idle();
        target += PHASE_ITEMS / 2;
        run_phase(target);
        set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        no_idle = 1'b1;
        target += PHASE_ITEMS;
        run_phase(target);
        no_idle = 1'b0;
        dup = 8'($urandom);
        set_codes(8'($urandom), dup, dup, 8'($urandom));
        target += PHASE_ITEMS;
        run_phase(target);
        set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        target += PHASE_ITEMS;
        run_phase(target);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_idle    = 1'b0;
        err_count  = 0;
        items_sent = 0;
        cycles     = 0;
        hdr_code[CMD_GET] = RST_CODE_GET;
        hdr_code[CMD_SET] = RST_CODE_SET;
        hdr_code[CMD_DEL] = RST_CODE_DEL;
        hdr_code[CMD_RES] = RST_CODE_RES;
        clear_parser();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_first_byte_is_header();
        test_store_request();
        test_delete_response_and_reject();
        test_restart_mid_request();
        test_header_codes();
        test_random_traffic();

        wait_idle();
        repeat (4) @(posedge aclk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
